// ===== src/mmp_pkg.sv =====
package mmp_pkg;

  localparam int unsigned CFG_DW = 18;
  localparam int unsigned KW = 10;
  localparam int unsigned NORM_W = 20;
  localparam logic [NORM_W-1:0] NORM_MAX = 20'hFFFFF;
  localparam int unsigned KEPT_MAX = 1023;

  // Shared divider: numerator and denominator widths.
  localparam int unsigned DIV_NW = 31;
  localparam int unsigned DIV_DW = 20;

  localparam logic CFG_PAD_ID = 1'b0;
  localparam logic CFG_OUT_DIM = 1'b1;

  localparam logic [1:0] MODE_ACC = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] hidden_value;
    logic [17:0]        token_id;
    logic               beyond_tokens;
    logic [8:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pooled_value;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ===== src/mmp_in_if.sv =====
interface mmp_in_if;
  import mmp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/mmp_out_if.sv =====
interface mmp_out_if;
  import mmp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/masked_mean_pool_l2_norm_top.sv =====
// Masked mean pooling with L2 normalization of a hidden-state matrix.
// Input beats on in_i carry a mode: accumulate streams hidden elements row
// by row (the dimension index is counted inside), finish turns the sums into
// the mean vector and its norm, read returns one normalized Q1.15 element.
// Each finish and each read yields one result beat on out_o; accumulate and
// the unused mode yield none. The user must write pad_id and out_dim on the
// cfg port only while the block is idle; the block does not enforce this.
// Sequencing: an accumulate beat reads the sum memory, then adds and writes
// back. A refused read goes straight to the output; a read with a zero norm
// passes S_RDV, any other read also runs the bit-serial divider. A finish
// with kept rows passes every mean through the same 31-step divider and a
// square-and-add step, then runs a bit-pair integer square root.
// in_i.ready is high only while the sequencer idles. A result waits in the
// output register; if the receiver stalls, the next result waits in the
// sequencer until the register frees, while earlier beats are kept.
// Reset leaves the block finished with no kept rows; the sum memory is
// cleared row-wise by the first row after each finish, with no sweep.
module masked_mean_pool_l2_norm_top #(
  parameter int unsigned DIM = 384,
  parameter int unsigned MAX_SEQ = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [mmp_pkg::CFG_DW-1:0]  cfg_data_i,
  mmp_in_if.sink                      in_i,
  mmp_out_if.source                   out_o
);
  import mmp_pkg::*;

  localparam int unsigned PW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned CW = ((PW > 9) ? PW : 9) + 1;
  localparam int unsigned CAP = (MAX_SEQ < KEPT_MAX) ? MAX_SEQ : KEPT_MAX;
  localparam int unsigned SQW = 31 + $clog2(DIM);
  localparam int unsigned SQE = SQW + (SQW % 2);
  localparam int unsigned DCW = $clog2(DIV_NW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_FRD  = 4'd2;
  localparam logic [3:0] S_FDV  = 4'd3;
  localparam logic [3:0] S_FDIV = 4'd4;
  localparam logic [3:0] S_FSQ  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_RDV  = 4'd7;
  localparam logic [3:0] S_RDIV = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // Saturate a signed magnitude-and-sign quotient to 16 bits.
  function automatic logic signed [15:0] sat_q(input logic neg, input logic [DIV_NW-1:0] q);
    logic signed [15:0] r;
    if (!neg) begin
      r = (q > DIV_NW'(32767)) ? 16'sh7FFF : 16'(q);
    end else begin
      r = (q > DIV_NW'(32768)) ? 16'sh8000 : 16'(-q);
    end
    return r;
  endfunction

  logic [3:0]            state_q, state_d;
  logic [17:0]           pad_q;
  logic [8:0]            out_dim_q;
  logic [PW-1:0]         pos_q, pos_d;
  logic [KW-1:0]         kept_q, kept_d;
  logic                  finished_q, finished_d;
  logic                  first_pass_q, first_pass_d;
  logic                  means_zero_q, means_zero_d;
  logic [NORM_W-1:0]     norm_q, norm_d;
  logic                  acc_kept_q, acc_kept_d;
  logic signed [15:0]    acc_hv_q, acc_hv_d;
  logic [PW-1:0]         cnt_q, cnt_d;
  logic signed [15:0]    mean_q, mean_d;
  logic                  neg_q, neg_d;
  logic [DIV_DW-1:0]     div_rem_q, div_rem_d;
  logic [DIV_NW-1:0]     div_quo_q, div_quo_d;
  logic [DIV_DW-1:0]     div_den_q, div_den_d;
  logic [DCW-1:0]        div_cnt_q, div_cnt_d;
  logic [SQE-1:0]        sq_v_q, sq_v_d;
  logic [SQE-1:0]        sq_r_q, sq_r_d;
  logic [SQE-1:0]        sq_bit_q, sq_bit_d;
  out_item_t             res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_data_q, out_data_d;

  logic                  sum_we;
  logic [24:0]           sum_wdata, sum_rdata;
  logic [PW-1:0]         sum_raddr;
  logic                  pm_we;
  logic [15:0]           pm_rdata;
  logic [PW-1:0]         pm_raddr;

  logic                  in_acc;
  logic [KW-1:0]         kept_eff;
  logic                  elem_kept;
  logic [CW-1:0]         idx_ext, lim;
  logic signed [24:0]    old_sum, sum_src;
  logic signed [25:0]    sum_add;
  logic signed [24:0]    sum_sat;
  logic [24:0]           sum_mag;
  logic [DIV_DW:0]       rem_sh;
  logic                  div_take;
  logic [DIV_NW-1:0]     quo_next;
  logic signed [15:0]    rd_m;
  logic [15:0]           rd_mag;
  logic signed [18:0]    rd_x8;
  logic signed [31:0]    sq_prod;
  logic [SQE-1:0]        sq_try;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data = out_data_q;

  assign kept_eff = finished_q ? '0 : kept_q;
  assign elem_kept = !in_i.data.beyond_tokens && (in_i.data.token_id != pad_q) &&
                     (kept_eff < KW'(CAP));
  assign idx_ext = CW'(in_i.data.read_index);
  assign lim = (CW'(out_dim_q) > CW'(DIM)) ? CW'(DIM) : CW'(out_dim_q);
  assign pm_raddr = idx_ext[PW-1:0];
  assign sum_raddr = (state_q == S_IDLE) ? (finished_q ? '0 : pos_q) : cnt_q;

  // Accumulate: the first row after a finish sees zero in place of old sums.
  assign old_sum = first_pass_q ? '0 : $signed(sum_rdata);
  assign sum_add = {old_sum[24], old_sum} + 26'($signed(acc_hv_q));
  assign sum_sat = (sum_add > 26'sd16777215) ? 25'sd16777215 :
                   (sum_add < -26'sd16777216) ? -25'sd16777216 : sum_add[24:0];
  assign sum_wdata = acc_kept_q ? sum_sat : old_sum;
  assign sum_we = (state_q == S_ACC);

  // Finish: entries past the fill point of an unfinished first row are zero.
  assign sum_src = (!first_pass_q || (cnt_q < pos_q)) ? $signed(sum_rdata) : '0;
  assign sum_mag = sum_src[24] ? 25'(-sum_src) : 25'(sum_src);

  assign rem_sh = {div_rem_q, div_quo_q[DIV_NW-1]};
  assign div_take = (rem_sh >= {1'b0, div_den_q});
  assign quo_next = {div_quo_q[DIV_NW-2:0], div_take};

  assign rd_m = means_zero_q ? '0 : $signed(pm_rdata);
  assign rd_mag = rd_m[15] ? 16'(-rd_m) : 16'(rd_m);
  assign rd_x8 = {{3{rd_m[15]}}, rd_m} <<< 3;

  assign sq_prod = mean_q * mean_q;
  assign sq_try = sq_r_q + sq_bit_q;
  assign pm_we = (state_q == S_FSQ);

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    kept_d = kept_q;
    finished_d = finished_q;
    first_pass_d = first_pass_q;
    means_zero_d = means_zero_q;
    norm_d = norm_q;
    acc_kept_d = acc_kept_q;
    acc_hv_d = acc_hv_q;
    cnt_d = cnt_q;
    mean_d = mean_q;
    neg_d = neg_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_den_d = div_den_q;
    div_cnt_d = div_cnt_q;
    sq_v_d = sq_v_q;
    sq_r_d = sq_r_q;
    sq_bit_d = sq_bit_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d.pooled_value = '0;
          res_d.status = ST_OK;
          case (in_i.data.mode)
            MODE_ACC: begin
              if (finished_q) begin
                pos_d = '0;
                kept_d = '0;
                first_pass_d = 1'b1;
                finished_d = 1'b0;
              end
              acc_kept_d = elem_kept;
              acc_hv_d = in_i.data.hidden_value;
              state_d = S_ACC;
            end
            MODE_FINISH: begin
              finished_d = 1'b1;
              if (kept_q == '0) begin
                means_zero_d = 1'b1;
                norm_d = '0;
                res_d.status = ST_EMPTY;
                state_d = S_OUT;
              end else begin
                means_zero_d = 1'b0;
                cnt_d = '0;
                sq_v_d = '0;
                state_d = S_FRD;
              end
            end
            MODE_READ: begin
              if (idx_ext >= lim) begin
                res_d.status = ST_RANGE;
                state_d = S_OUT;
              end else if (finished_q && (kept_q == '0)) begin
                res_d.status = ST_EMPTY;
                state_d = S_OUT;
              end else begin
                state_d = S_RDV;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ACC: begin
        if (pos_q == PW'(DIM - 1)) begin
          pos_d = '0;
          first_pass_d = 1'b0;
          if (acc_kept_q) begin
            kept_d = kept_q + 1'b1;
          end
        end else begin
          pos_d = pos_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      S_FRD: state_d = S_FDV;
      S_FDV: begin
        neg_d = sum_src[24];
        div_rem_d = '0;
        div_quo_d = DIV_NW'(sum_mag) + DIV_NW'(kept_q >> 1);
        div_den_d = DIV_DW'(kept_q);
        div_cnt_d = '0;
        state_d = S_FDIV;
      end
      S_FDIV, S_RDIV: begin
        div_rem_d = div_take ? DIV_DW'(rem_sh - {1'b0, div_den_q}) : DIV_DW'(rem_sh);
        div_quo_d = quo_next;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DCW'(DIV_NW - 1)) begin
          if (state_q == S_FDIV) begin
            mean_d = sat_q(neg_q, quo_next);
            state_d = S_FSQ;
          end else begin
            res_d.pooled_value = sat_q(neg_q, quo_next);
            state_d = S_OUT;
          end
        end
      end
      S_FSQ: begin
        sq_v_d = sq_v_q + SQE'(sq_prod[30:0]);
        if (cnt_q == PW'(DIM - 1)) begin
          sq_r_d = '0;
          sq_bit_d = SQE'(1) << (SQE - 2);
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
          state_d = S_FRD;
        end
      end
      S_SQRT: begin
        if (sq_bit_q == '0) begin
          norm_d = (sq_r_q > SQE'(NORM_MAX)) ? NORM_MAX : sq_r_q[NORM_W-1:0];
          state_d = S_OUT;
        end else begin
          if (sq_v_q >= sq_try) begin
            sq_v_d = sq_v_q - sq_try;
            sq_r_d = (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_d = sq_r_q >> 1;
          end
          sq_bit_d = sq_bit_q >> 2;
        end
      end
      S_RDV: begin
        if (norm_q == '0) begin
          res_d.pooled_value = (rd_x8 > 19'sd32767) ? 16'sh7FFF :
                               (rd_x8 < -19'sd32768) ? 16'sh8000 : rd_x8[15:0];
          state_d = S_OUT;
        end else begin
          neg_d = rd_m[15];
          div_rem_d = '0;
          div_quo_d = {rd_mag, 15'b0} + DIV_NW'(norm_q >> 1);
          div_den_d = norm_q;
          div_cnt_d = '0;
          state_d = S_RDIV;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d = res_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pad_q <= '0;
      out_dim_q <= 9'd384;
      pos_q <= '0;
      kept_q <= '0;
      finished_q <= 1'b1;
      first_pass_q <= 1'b0;
      means_zero_q <= 1'b0;
      norm_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_idx_i == CFG_PAD_ID)) begin
        pad_q <= cfg_data_i[17:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_OUT_DIM)) begin
        out_dim_q <= cfg_data_i[8:0];
      end
      pos_q <= pos_d;
      kept_q <= kept_d;
      finished_q <= finished_d;
      first_pass_q <= first_pass_d;
      means_zero_q <= means_zero_d;
      norm_q <= norm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_kept_q <= acc_kept_d;
    acc_hv_q <= acc_hv_d;
    cnt_q <= cnt_d;
    mean_q <= mean_d;
    neg_q <= neg_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    div_cnt_q <= div_cnt_d;
    sq_v_q <= sq_v_d;
    sq_r_q <= sq_r_d;
    sq_bit_q <= sq_bit_d;
    res_q <= res_d;
    out_data_q <= out_data_d;
  end

  mmp_ram #(.W(25), .D(DIM)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (pos_q),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  mmp_ram #(.W(16), .D(DIM)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (cnt_q),
    .wdata_i (mean_q),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );
endmodule

// ===== src/mmp_ram.sv =====
module mmp_ram #(
  parameter int unsigned W = 16,
  parameter int unsigned D = 384
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                         wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                         rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/mmp_chk.sv =====
module mmp_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic [1:0]              in_mode_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input mmp_pkg::out_item_t      out_data_i
);
  import mmp_pkg::*;

  // A result held against a stalled receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // A refused or empty answer carries a zero value.
  a_zero_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != ST_OK) |-> out_data_i.pooled_value == '0)
    else $error("nonzero value with fault status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.status != 2'd3)
    else $error("undefined status code");

  // An accumulate beat occupies the sequencer for its write-back cycle.
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_ACC) |=> !in_ready_i)
    else $error("ready during accumulate write-back");
endmodule

bind masked_mean_pool_l2_norm_top mmp_chk u_mmp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.data.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
